// ===== rtl/saturating_voice_mixer_core_defines.svh =====
// ----------------------------------------------------------------------------
// saturating voice mixer defines
// assertion macros shared by the rtl; empty when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef SATURATING_VOICE_MIXER_CORE_DEFINES_SVH
`define SATURATING_VOICE_MIXER_CORE_DEFINES_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define SVM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("svm assertion failed");

// antecedent implies consequent in the next cycle
`define SVM_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("svm assertion failed");

`else

`define SVM_ASSERT_IMP(label, clk, rst, ante, cons)
`define SVM_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/svm_pkg.sv =====
// ----------------------------------------------------------------------------
// svm_pkg
// shared types, constants and clamp arithmetic of the voice mixer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package svm_pkg;

  localparam int NUM_LANE_PORTS = 8;   // lane sample fields on the input channel
  localparam int LANES          = 8;   // lanes that take part in the mix, 1..8
  localparam int SAMPLE_W       = 8;
  localparam int OFS_W          = 11;  // holds a sum of eight lane offsets
  localparam int SUM_W          = 12;  // offset plus an 8-bit level

  localparam logic [SAMPLE_W-1:0] SILENCE    = 8'd128;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 8'd0;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 8'd255;

  // transfer function x -> clamp(x + ofs, lo, hi), lo <= hi
  typedef struct packed {
    logic [SAMPLE_W-1:0]     lo;
    logic [SAMPLE_W-1:0]     hi;
    logic signed [OFS_W-1:0] ofs;
  } lane_fn_t;

  typedef struct packed {
    logic first;
    logic last;
  } grp_ctrl_t;

  function automatic logic [SAMPLE_W-1:0] clamp_add(
    input logic [SAMPLE_W-1:0]     base,
    input logic signed [OFS_W-1:0] ofs,
    input logic [SAMPLE_W-1:0]     lo,
    input logic [SAMPLE_W-1:0]     hi
  );
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] lo_s;
    logic signed [SUM_W-1:0] hi_s;
    logic [SAMPLE_W-1:0]     res;
    sum  = $signed({{(SUM_W-SAMPLE_W){1'b0}}, base}) +
           $signed({{(SUM_W-OFS_W){ofs[OFS_W-1]}}, ofs});
    lo_s = $signed({{(SUM_W-SAMPLE_W){1'b0}}, lo});
    hi_s = $signed({{(SUM_W-SAMPLE_W){1'b0}}, hi});
    if (sum < lo_s) begin
      res = lo;
    end else if (sum > hi_s) begin
      res = hi;
    end else begin
      res = sum[SAMPLE_W-1:0];
    end
    return res;
  endfunction

  // apply f first, then g
  function automatic lane_fn_t compose(input lane_fn_t f, input lane_fn_t g);
    lane_fn_t r;
    r.ofs = f.ofs + g.ofs;
    r.lo  = clamp_add(f.lo, g.ofs, g.lo, g.hi);
    r.hi  = clamp_add(f.hi, g.ofs, g.lo, g.hi);
    return r;
  endfunction

endpackage

// ===== rtl/svm_if.sv =====
// ----------------------------------------------------------------------------
// svm channel interfaces
// valid/ready channels for lane groups in and mixed samples out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface svm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample_lane0;
  logic [7:0] sample_lane1;
  logic [7:0] sample_lane2;
  logic [7:0] sample_lane3;
  logic [7:0] sample_lane4;
  logic [7:0] sample_lane5;
  logic [7:0] sample_lane6;
  logic [7:0] sample_lane7;
  logic [7:0] lane_valid;
  logic       first_group;
  logic       last_group;

  modport source (
    output valid, sample_lane0, sample_lane1, sample_lane2, sample_lane3,
           sample_lane4, sample_lane5, sample_lane6, sample_lane7,
           lane_valid, first_group, last_group,
    input  ready
  );
  modport sink (
    input  valid, sample_lane0, sample_lane1, sample_lane2, sample_lane3,
           sample_lane4, sample_lane5, sample_lane6, sample_lane7,
           lane_valid, first_group, last_group,
    output ready
  );
endinterface

interface svm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] mixed_sample;

  modport source (output valid, mixed_sample, input ready);
  modport sink (input valid, mixed_sample, output ready);
endinterface

// ===== rtl/svm_lane.sv =====
// ----------------------------------------------------------------------------
// svm_lane
// one mixer lane: turns a voice sample into a registered clamp-add function
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svm_lane (
  input  logic                            clk,
  input  logic                            load,
  input  logic                            lane_on,
  input  logic                            sample_valid,
  input  logic [svm_pkg::SAMPLE_W-1:0]    sample,
  output svm_pkg::lane_fn_t               fn
);
  import svm_pkg::*;

  lane_fn_t fn_next;

  always_comb begin
    fn_next.lo = SAMPLE_MIN;
    fn_next.hi = SAMPLE_MAX;
    if (lane_on && sample_valid) begin
      // sample - 128 as a signed offset
      fn_next.ofs = {{(OFS_W-SAMPLE_W){~sample[SAMPLE_W-1]}}, ~sample[SAMPLE_W-1],
                     sample[SAMPLE_W-2:0]};
    end else begin
      fn_next.ofs = '0;   // identity
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fn <= fn_next;
    end
  end

endmodule

// ===== rtl/svm_merge.sv =====
// ----------------------------------------------------------------------------
// svm_merge
// composes the lane functions in lane order through a tree, registered result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svm_merge (
  input  logic              clk,
  input  logic              load,
  input  svm_pkg::lane_fn_t fns [svm_pkg::NUM_LANE_PORTS],
  output svm_pkg::lane_fn_t merged
);
  import svm_pkg::*;

  localparam int L1 = NUM_LANE_PORTS / 2;
  localparam int L2 = NUM_LANE_PORTS / 4;

  lane_fn_t lvl1 [L1];
  lane_fn_t lvl2 [L2];
  lane_fn_t merged_next;

  // lower lane is applied first at every node
  always_comb begin
    for (int i = 0; i < L1; i++) begin
      lvl1[i] = compose(fns[2*i], fns[2*i+1]);
    end
    for (int i = 0; i < L2; i++) begin
      lvl2[i] = compose(lvl1[2*i], lvl1[2*i+1]);
    end
    merged_next = compose(lvl2[0], lvl2[1]);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      merged <= merged_next;
    end
  end

endmodule

// ===== rtl/saturating_voice_mixer_core.sv =====
// ----------------------------------------------------------------------------
// saturating_voice_mixer_core
// mixes offset-binary voice lanes with per-lane saturation into one sample
// ----------------------------------------------------------------------------
// Takes one lane group per clock unless stalled and registers a mixed byte
// once a group marked last has passed the lane and merge registers. Each lane
// turns its sample into a clamp-add function, a three-level tree composes
// them in lane order so the saturation order is kept, and a single clamp-add
// applies the result to the 8-bit accumulator. The accumulator update is the
// only loop, so groups follow back to back; input stalls only when the output
// register holds an untaken byte, stage 2 a last group and stage 1 is full.
`timescale 1ns / 1ps
`include "saturating_voice_mixer_core_defines.svh"

module saturating_voice_mixer_core (
  input  logic      clk,
  input  logic      rst,
  svm_in_if.sink    voice_in,
  svm_out_if.source mix_out
);
  import svm_pkg::*;

  // lane samples gathered into an array for the lane instances
  logic [SAMPLE_W-1:0] lane_sample [NUM_LANE_PORTS];
  lane_fn_t            lane_fn     [NUM_LANE_PORTS];
  lane_fn_t            merged;

  // pipeline control
  logic      s1_valid;
  grp_ctrl_t s1_ctrl;
  logic      s2_valid;
  grp_ctrl_t s2_ctrl;
  logic      in_take;
  logic      s1_move;
  logic      s2_adv;

  // mix state and output register
  logic [SAMPLE_W-1:0] acc;
  logic [SAMPLE_W-1:0] acc_next;
  logic [SAMPLE_W-1:0] acc_base;
  logic                out_valid;
  logic [SAMPLE_W-1:0] out_data;

  assign lane_sample[0] = voice_in.sample_lane0;
  assign lane_sample[1] = voice_in.sample_lane1;
  assign lane_sample[2] = voice_in.sample_lane2;
  assign lane_sample[3] = voice_in.sample_lane3;
  assign lane_sample[4] = voice_in.sample_lane4;
  assign lane_sample[5] = voice_in.sample_lane5;
  assign lane_sample[6] = voice_in.sample_lane6;
  assign lane_sample[7] = voice_in.sample_lane7;

  // a last group may only leave stage 2 when the output register is free
  assign s2_adv   = s2_valid && (!s2_ctrl.last || !out_valid || mix_out.ready);
  assign s1_move  = s1_valid && (!s2_valid || s2_adv);
  assign voice_in.ready = !s1_valid || s1_move;
  assign in_take  = voice_in.valid && voice_in.ready;

  // stage 1: per-lane functions
  for (genvar i = 0; i < NUM_LANE_PORTS; i++) begin : g_lane
    svm_lane u_lane (
      .clk          (clk),
      .load         (in_take),
      .lane_on      (i < LANES),
      .sample_valid (voice_in.lane_valid[i]),
      .sample       (lane_sample[i]),
      .fn           (lane_fn[i])
    );
  end

  // stage 2: composed group function
  svm_merge u_merge (
    .clk    (clk),
    .load   (s1_move),
    .fns    (lane_fn),
    .merged (merged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        s2_valid <= 1'b1;
      end else if (s2_adv) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_ctrl.first <= voice_in.first_group;
      s1_ctrl.last  <= voice_in.last_group;
    end
    if (s1_move) begin
      s2_ctrl <= s1_ctrl;
    end
  end

  // stage 3: apply group function to the accumulator, restart at silence
  assign acc_base = s2_ctrl.first ? SILENCE : acc;
  assign acc_next = clamp_add(acc_base, merged.ofs, merged.lo, merged.hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= SILENCE;
    end else if (s2_adv) begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_adv && s2_ctrl.last) begin
      out_valid <= 1'b1;
    end else if (mix_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s2_ctrl.last) begin
      out_data <= acc_next;
    end
  end

  assign mix_out.valid        = out_valid;
  assign mix_out.mixed_sample = out_data;

  // a held result is never overwritten by a last group
  `SVM_ASSERT_IMP(a_no_overwrite, clk, rst, s2_adv && s2_ctrl.last, !out_valid || mix_out.ready)
  // results come only from last groups leaving stage 2
  `SVM_ASSERT_NXT(a_out_from_last, clk, rst, !(s2_adv && s2_ctrl.last) && !(out_valid && !mix_out.ready), !mix_out.valid)
  // accumulator moves only with a group
  `SVM_ASSERT_NXT(a_acc_hold, clk, rst, !s2_adv, $stable(acc))
  // an empty front stage always takes input
  `SVM_ASSERT_IMP(a_ready_empty, clk, rst, !s1_valid, voice_in.ready)

endmodule

// ===== dv/voice_mix_checker.sv =====
// ----------------------------------------------------------------------------
// voice_mix_checker
// watches the lane group and mixed sample channels, predicts each mixed byte
// and compares it with the one the mixer returns
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module voice_mix_checker (
  input  logic clk,
  input  logic rst,
  svm_in_if    grp_ch,
  svm_out_if   mix_ch,
  output int   mix_errors,
  output int   expected_left
);

  import svm_pkg::*;

  logic [SAMPLE_W-1:0] mix_level;
  logic [SAMPLE_W-1:0] voices [NUM_LANE_PORTS];
  logic [SAMPLE_W-1:0] want;
  logic [SAMPLE_W-1:0] mixed_expect_q [$];

  // one lane into the running level, clamped right away
  function automatic logic [SAMPLE_W-1:0] apply_voice(input logic [SAMPLE_W-1:0] level,
                                                      input logic [SAMPLE_W-1:0] voice);
    int unsigned total;
    total = level + voice;
    if (total < SILENCE) begin
      return SAMPLE_MIN;
    end
    total = total - SILENCE;
    if (total > SAMPLE_MAX) begin
      return SAMPLE_MAX;
    end
    return total[SAMPLE_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      mix_level = SILENCE;
      mixed_expect_q.delete();
      mix_errors <= 0;
    end else begin
      if (grp_ch.valid && grp_ch.ready) begin
        voices[0] = grp_ch.sample_lane0;
        voices[1] = grp_ch.sample_lane1;
        voices[2] = grp_ch.sample_lane2;
        voices[3] = grp_ch.sample_lane3;
        voices[4] = grp_ch.sample_lane4;
        voices[5] = grp_ch.sample_lane5;
        voices[6] = grp_ch.sample_lane6;
        voices[7] = grp_ch.sample_lane7;
        if (grp_ch.first_group) begin
          mix_level = SILENCE;
        end
        for (int i = 0; i < LANES && i < NUM_LANE_PORTS; i++) begin
          if (grp_ch.lane_valid[i]) begin
            mix_level = apply_voice(mix_level, voices[i]);
          end
        end
        if (grp_ch.last_group) begin
          mixed_expect_q.push_back(mix_level);
        end
      end
      if (mix_ch.valid && mix_ch.ready) begin
        if (mixed_expect_q.size() == 0) begin
          $error("mixed_sample with nothing expected, actual %0d", mix_ch.mixed_sample);
          mix_errors <= mix_errors + 1;
        end else begin
          want = mixed_expect_q.pop_front();
          if (mix_ch.mixed_sample !== want) begin
            $error("mixed_sample expected %0d actual %0d", want, mix_ch.mixed_sample);
            mix_errors <= mix_errors + 1;
          end
        end
      end
    end
    expected_left <= mixed_expect_q.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// drives lane groups into the saturating voice mixer and collects the mixed
// bytes with random stalls on both sides; the checker beside the mixer
// predicts every byte and this module only gives the verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  import svm_pkg::*;

  localparam int RANDOM_ITEMS   = 1100;
  localparam int QUIET_TAIL     = 120;     // last items run with no idling at all
  localparam int RX_HOLD_CYCLES = 100;     // long output stall to fill the pipeline
  localparam int DRAIN_CYCLES   = 16;      // idle time after the final drain to catch stray bytes
  localparam int CYCLE_LIMIT    = 400000;

  // one lane group as the sender sees it, lane 0 in the low byte
  typedef struct packed {
    logic [NUM_LANE_PORTS-1:0][SAMPLE_W-1:0] voice;
    logic [NUM_LANE_PORTS-1:0]               mask;
    logic                                    first;
    logic                                    last;
  } mix_group_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycle_count = 0;
  int   mix_errors;
  int   expected_left;

  // handshake between the sender and the receiver process
  logic rx_hold_req = 1'b0;
  logic rx_quiet    = 1'b0;
  int   sender_gap_pct = 20;

  svm_in_if  voice_ch ();
  svm_out_if mix_ch ();

  saturating_voice_mixer_core dut (
    .clk      (clk),
    .rst      (rst),
    .voice_in (voice_ch),
    .mix_out  (mix_ch)
  );

  voice_mix_checker chk (
    .clk           (clk),
    .rst           (rst),
    .grp_ch        (voice_ch),
    .mix_ch        (mix_ch),
    .mix_errors    (mix_errors),
    .expected_left (expected_left)
  );

  always #5 clk = ~clk;

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // helpers for building groups
  // ---------------------------------------------------------------------------

  // samples lean toward silence and the two rails so saturation shows up often
  function automatic logic [SAMPLE_W-1:0] pick_voice();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MIN;
      1:       return SAMPLE_MAX;
      2:       return SILENCE;
      3:       return 8'($urandom_range(0, 8));
      4:       return 8'($urandom_range(247, 255));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [NUM_LANE_PORTS-1:0] pick_mask();
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return '0;
      2:       return 8'(1 << $urandom_range(0, NUM_LANE_PORTS - 1));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic mix_group_t random_group(input logic first, input logic last);
    mix_group_t g;
    for (int i = 0; i < NUM_LANE_PORTS; i++) begin
      g.voice[i] = pick_voice();
    end
    g.mask  = pick_mask();
    g.first = first;
    g.last  = last;
    return g;
  endfunction

  // all lanes at one level, mixing only the lanes in mask
  function automatic mix_group_t flat_group(input logic [SAMPLE_W-1:0] level,
                                            input logic [NUM_LANE_PORTS-1:0] mask,
                                            input logic first, input logic last);
    mix_group_t g;
    g.voice = {NUM_LANE_PORTS{level}};
    g.mask  = mask;
    g.first = first;
    g.last  = last;
    return g;
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  task automatic drive_group(input mix_group_t g, input logic offer);
    voice_ch.valid        <= offer;
    voice_ch.sample_lane0 <= g.voice[0];
    voice_ch.sample_lane1 <= g.voice[1];
    voice_ch.sample_lane2 <= g.voice[2];
    voice_ch.sample_lane3 <= g.voice[3];
    voice_ch.sample_lane4 <= g.voice[4];
    voice_ch.sample_lane5 <= g.voice[5];
    voice_ch.sample_lane6 <= g.voice[6];
    voice_ch.sample_lane7 <= g.voice[7];
    voice_ch.lane_valid   <= g.mask;
    voice_ch.first_group  <= g.first;
    voice_ch.last_group   <= g.last;
  endtask

  // hold the group until it transfers, then maybe leave a gap; valid stays
  // high across back-to-back groups so it never drops and rises in one step
  task automatic offer_group(input mix_group_t g);
    drive_group(g, 1'b1);
    @(posedge clk);
    while (!voice_ch.ready) @(posedge clk);
    if (sender_gap_pct != 0 && $urandom_range(0, 99) < sender_gap_pct) begin
      voice_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // stop offering until every predicted byte has come out; the extra edge
  // lets the checker count the group that transferred on this one
  task automatic drain_results();
    voice_ch.valid <= 1'b0;
    @(posedge clk);
    wait (expected_left == 0);
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // output side: short random stalls, long calm stretches, one long hold
  // ---------------------------------------------------------------------------
  initial begin
    mix_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        // long hold so the mixer fills up and pushes back on its input
        rx_hold_req = 1'b0;
        mix_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else if (!rx_quiet && $urandom_range(0, 5) == 0) begin
        mix_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        mix_ch.ready <= 1'b1;
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : 1) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and verdict
  // ---------------------------------------------------------------------------
  initial begin
    mix_group_t g;
    int         items_sent;
    int         seq_len;
    int         burst_left;
    logic       hold_done;
    logic       pause_done;
    logic       noise;

    items_sent = 0;
    burst_left = 0;
    hold_done  = 1'b0;
    pause_done = 1'b0;

    drive_group('0, 1'b0);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // -- directed part ------------------------------------------------------

    // no first mark right after reset: mixing starts from silence
    g = flat_group(SAMPLE_MIN, 8'h01, 1'b0, 1'b1);
    g.voice[0] = 8'd200;
    offer_group(g);
    // no first mark and no lanes after an emission: repeats the last byte
    offer_group(flat_group(8'd77, 8'h00, 1'b0, 1'b1));
    // restart with no voices gives silence
    offer_group(flat_group(8'd77, 8'h00, 1'b1, 1'b1));
    // every lane at a rail, clamped at the top and at the bottom
    offer_group(flat_group(SAMPLE_MAX, 8'hFF, 1'b1, 1'b1));
    offer_group(flat_group(SAMPLE_MIN, 8'hFF, 1'b1, 1'b1));

    // lane order matters once the level hits a rail: top clamp then a pull down
    g = flat_group(SAMPLE_MIN, 8'h07, 1'b1, 1'b1);
    g.voice[0] = SAMPLE_MAX;
    g.voice[1] = SAMPLE_MAX;
    offer_group(g);
    // bottom clamp then a push up
    g = flat_group(SAMPLE_MIN, 8'h07, 1'b1, 1'b1);
    g.voice[2] = SAMPLE_MAX;
    offer_group(g);
    // same samples with a masked-off lane in the middle
    g.mask = 8'h05;
    offer_group(g);

    // each lane alone, the others set to the opposite level so a wrong pick shows
    for (int i = 0; i < NUM_LANE_PORTS; i++) begin
      g = flat_group((i % 2) ? 8'hFE : 8'h01, 8'(1 << i), 1'b1, 1'b1);
      g.voice[i] = (i % 2) ? 8'h01 : 8'hFE;
      offer_group(g);
    end

    // one sample over three groups: open, middle, close
    offer_group(flat_group(8'd200, 8'hFF, 1'b1, 1'b0));
    offer_group(flat_group(SAMPLE_MIN, 8'h0F, 1'b0, 1'b0));
    g = flat_group(SAMPLE_MIN, 8'h01, 1'b0, 1'b1);
    g.voice[0] = SAMPLE_MAX;
    offer_group(g);
    // continue from the emitted byte with a near-silent lane
    g = flat_group(SAMPLE_MIN, 8'h01, 1'b0, 1'b1);
    g.voice[0] = 8'd129;
    offer_group(g);

    // sender pause: nothing offered until the pipeline has emptied
    drain_results();

    // -- random part --------------------------------------------------------
    while (items_sent < RANDOM_ITEMS) begin
      if (!hold_done && items_sent >= 300) begin
        // receiver goes quiet for a long while, sender keeps pushing
        hold_done   = 1'b1;
        rx_hold_req = 1'b1;
        burst_left  = 60;
      end
      if (!pause_done && items_sent >= 650) begin
        pause_done = 1'b1;
        drain_results();
      end

      if (items_sent >= RANDOM_ITEMS - QUIET_TAIL) begin
        rx_quiet       = 1'b1;
        sender_gap_pct = 0;
      end else if (burst_left > 0) begin
        sender_gap_pct = 0;
      end else begin
        case ($urandom_range(0, 3))
          0:       sender_gap_pct = 0;
          1:       sender_gap_pct = 10;
          default: sender_gap_pct = 30;
        endcase
      end

      // mostly well-formed samples of one to four groups, the rest loose marks
      noise   = ($urandom_range(0, 9) == 0);
      seq_len = noise ? $urandom_range(1, 3) : $urandom_range(1, 4);
      for (int k = 0; k < seq_len; k++) begin
        if (noise) begin
          g = random_group(1'($urandom), 1'($urandom));
        end else begin
          g = random_group(k == 0, k == seq_len - 1);
        end
        offer_group(g);
        items_sent++;
        if (burst_left > 0) begin
          burst_left--;
        end
      end
    end

    // wait out every outstanding byte, then idle for DRAIN_CYCLES to catch strays
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mix_errors == 0 && expected_left == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== saturating_voice_mixer_core.f =====
+incdir+rtl
rtl/svm_pkg.sv
rtl/svm_if.sv
rtl/svm_lane.sv
rtl/svm_merge.sv
rtl/saturating_voice_mixer_core.sv
dv/voice_mix_checker.sv
dv/tb_top.sv
